// ===== hw/rtl/fnv_pkg.sv =====
// Shared constants, micro-op codes and helper functions for the footstep noise voice.
package fnv_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int STEP_W = 5;

    localparam logic [31:0] MUL_A = 32'd747796405;
    localparam logic [31:0] ADD_C = 32'd2891336453;
    localparam logic [31:0] MIX_M = 32'd277803737;
    localparam logic [31:0] SEED_XOR = 32'h00005bd1;
    localparam logic [15:0] ENV_ONE = 16'd32767;

    localparam logic [STEP_W-1:0] FIRST_STEP = 5'd0;
    localparam logic [STEP_W-1:0] FIRST_RUN_STEP = 5'd3;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

    // Register indexes on the config port
    localparam logic [2:0] REG_BODY_COEF = 3'd0;
    localparam logic [2:0] REG_THIN_COEF = 3'd1;
    localparam logic [2:0] REG_THUMP_COEF = 3'd2;
    localparam logic [2:0] REG_ATTACK_FACTOR = 3'd3;
    localparam logic [2:0] REG_DECAY_FACTOR = 3'd4;
    localparam logic [2:0] REG_HIT_FACTOR = 3'd5;
    localparam logic [2:0] REG_RUSTLE_GAIN = 3'd6;
    localparam logic [2:0] REG_HIT_GAIN = 3'd7;

    // One micro-op per shared multiply
    typedef enum logic [3:0] {
        OP_SEED,
        OP_LCG,
        OP_HASH,
        OP_LP_B1,
        OP_LP_B2,
        OP_LP_THIN,
        OP_LP_T1,
        OP_LP_T2,
        OP_RUSTLE,
        OP_HITENV,
        OP_HITGAIN,
        OP_ATTACK,
        OP_DECAY,
        OP_ENV_A,
        OP_ENV_D,
        OP_ENV_H
    } op_t;

    // Micro-program: reseed and discarded draw, rustle path, thump path, mix, envelopes
    function automatic op_t fnv_step_op(input logic [STEP_W-1:0] step);
        op_t op;
        begin
            unique case (step)
                5'd0:    op = OP_SEED;
                5'd1:    op = OP_LCG;
                5'd2:    op = OP_HASH;
                5'd3:    op = OP_LCG;
                5'd4:    op = OP_HASH;
                5'd5:    op = OP_LP_B1;
                5'd6:    op = OP_LP_B2;
                5'd7:    op = OP_LP_THIN;
                5'd8:    op = OP_LCG;
                5'd9:    op = OP_HASH;
                5'd10:   op = OP_LP_T1;
                5'd11:   op = OP_LP_T2;
                5'd12:   op = OP_RUSTLE;
                5'd13:   op = OP_HITENV;
                5'd14:   op = OP_HITGAIN;
                5'd15:   op = OP_ATTACK;
                5'd16:   op = OP_DECAY;
                5'd17:   op = OP_ENV_A;
                5'd18:   op = OP_ENV_D;
                default: op = OP_ENV_H;
            endcase
            return op;
        end
    endfunction

    // Hash input before the mixing multiply
    function automatic logic [31:0] fnv_hash_pre(input logic [31:0] r);
        logic [4:0] sh;
        begin
            sh = {1'b0, r[31:28]} + 5'd4;
            return (r >> sh) ^ r;
        end
    endfunction

    // Finish the hash and center the draw to Q2.22 noise
    function automatic logic signed [23:0] fnv_noise(input logic [31:0] w);
        logic [31:0] d;
        begin
            d = (w >> 22) ^ w;
            return $signed({1'b0, d[31:9]}) - 24'sh400000;
        end
    endfunction

    function automatic logic signed [23:0] fnv_sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        begin
            if (v > 26'sd8388607)
                r = 24'sh7fffff;
            else if (v < -26'sd8388608)
                r = 24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

    // Pole update: sat24(y + floor(coef * (x - y) / 2^15))
    function automatic logic signed [23:0] fnv_lp_update(input logic signed [23:0] y,
                                                         input logic signed [PROD_W-1:0] p);
        logic signed [25:0] sum;
        begin
            sum = 26'(y) + $signed(p[40:15]);
            return fnv_sat24(sum);
        end
    endfunction

endpackage

// ===== hw/rtl/fnv_mul.sv =====
// Shared signed multiplier with a registered product.
module fnv_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [fnv_pkg::MUL_W-1:0]    opa,
    input  logic signed [fnv_pkg::MUL_W-1:0]    opb,
    output logic signed [fnv_pkg::PROD_W-1:0]   prod
);
    import fnv_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // Product captured on the issue cycle only
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= opa * opb;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/footstep_noise_voice.sv =====
// Footstep noise voice top level: config registers, sequencer and datapath.
//
//  channel | direction | beat fields (lowest bit first)
//  --------+-----------+------------------------------------------
//  s_axis  | in        | tuser: start_req; tdata: seed[31:0]
//  m_axis  | out       | tdata: sample[15:0] signed
//  cfg     | in        | cfg_index: register index; cfg_data: value
//
// Each sample is an accept state and then an issue and a write back phase for
// each pass through the single 33x33 multiplier: 17 passes per tick and 3 more
// on a start tick for the reseed and the discarded draw.
// Reset loads the register defaults, zero seed state, clear poles, envelopes at one.
// The sample write back holds while the previous sample still waits on m_axis;
// input is taken only between ticks, the output register decouples the sides.
module footstep_noise_voice (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // seed[31:0]
    input  logic                              s_axis_tuser,   // start_req
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fnv_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,   // sample
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);
    import fnv_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic signed [PROD_W-1:0] SMP_MAX = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SMP_MIN = -PROD_W'(64'sd1 <<< (SAMPLE_BITS - 1));

    // Config registers
    logic [14:0] body_coef_reg, thin_coef_reg, thump_coef_reg;
    logic [14:0] attack_factor_reg, decay_factor_reg, hit_factor_reg;
    logic [15:0] rustle_gain_reg, hit_gain_reg;

    // Sequencer
    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              phase_reg;
    logic              out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    op_t               op;
    logic              in_fire;
    logic              out_free;
    logic              wb_hold;
    logic              smp_wb;

    // Voice state
    logic [31:0]        seed_reg;
    logic [31:0]        rng_reg;
    logic signed [23:0] noise_reg;
    logic signed [23:0] bp1_reg, bp2_reg, tp_reg, tp1_reg, tp2_reg;
    logic signed [23:0] hp_reg;
    logic signed [24:0] t_reg;
    logic signed [27:0] acc_reg;
    logic [15:0]        attack_env_reg, decay_env_reg, hit_env_reg;

    // Multiplier port
    logic signed [MUL_W-1:0]  opa, opb;
    logic signed [PROD_W-1:0] prod;
    logic signed [24:0]       lp_diff;
    logic signed [23:0]       lp_x, lp_y;
    logic [14:0]              lp_coef;
    logic signed [PROD_W-1:0] smp_shift;
    logic [SAMPLE_BITS-1:0]   smp_sat;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign op = fnv_step_op(step_reg);
    assign wb_hold = (op == OP_DECAY) && !out_free;
    assign smp_wb = (state_reg == ST_RUN) && phase_reg && (op == OP_DECAY) && !wb_hold;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_coef_reg     <= 15'd4096;
            thin_coef_reg     <= 15'd768;
            thump_coef_reg    <= 15'd470;
            attack_factor_reg <= 15'd32155;
            decay_factor_reg  <= 15'd32744;
            hit_factor_reg    <= 15'd32706;
            rustle_gain_reg   <= 16'd9011;
            hit_gain_reg      <= 16'd36045;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BODY_COEF:     body_coef_reg     <= cfg_data[14:0];
                REG_THIN_COEF:     thin_coef_reg     <= cfg_data[14:0];
                REG_THUMP_COEF:    thump_coef_reg    <= cfg_data[14:0];
                REG_ATTACK_FACTOR: attack_factor_reg <= cfg_data[14:0];
                REG_DECAY_FACTOR:  decay_factor_reg  <= cfg_data[14:0];
                REG_HIT_FACTOR:    hit_factor_reg    <= cfg_data[14:0];
                REG_RUSTLE_GAIN:   rustle_gain_reg   <= cfg_data;
                REG_HIT_GAIN:      hit_gain_reg      <= cfg_data;
                default:           hit_gain_reg      <= cfg_data;
            endcase
        end
    end

    // Low pass source selection
    always_comb
    begin
        lp_x = noise_reg;
        lp_y = bp1_reg;
        lp_coef = body_coef_reg;
        unique case (op)
            OP_LP_B2:
            begin
                lp_x = bp1_reg;
                lp_y = bp2_reg;
            end
            OP_LP_THIN:
            begin
                lp_x = bp2_reg;
                lp_y = tp_reg;
                lp_coef = thin_coef_reg;
            end
            OP_LP_T1:
            begin
                lp_y = tp1_reg;
                lp_coef = thump_coef_reg;
            end
            OP_LP_T2:
            begin
                lp_x = tp1_reg;
                lp_y = tp2_reg;
                lp_coef = thump_coef_reg;
            end
            default:
            begin
                lp_x = noise_reg;
                lp_y = bp1_reg;
                lp_coef = body_coef_reg;
            end
        endcase
        lp_diff = 25'(lp_x) - 25'(lp_y);
    end

    // Operand mux for the shared multiplier
    always_comb
    begin
        unique case (op)
            OP_SEED:
            begin
                opa = {1'b0, seed_reg ^ SEED_XOR};
                opb = {1'b0, MUL_A};
            end
            OP_LCG:
            begin
                opa = {1'b0, rng_reg};
                opb = {1'b0, MUL_A};
            end
            OP_HASH:
            begin
                opa = {1'b0, fnv_hash_pre(rng_reg)};
                opb = {1'b0, MIX_M};
            end
            OP_LP_B1, OP_LP_B2, OP_LP_THIN, OP_LP_T1, OP_LP_T2:
            begin
                opa = MUL_W'(lp_diff);
                opb = {18'd0, lp_coef};
            end
            OP_RUSTLE:
            begin
                opa = MUL_W'(hp_reg);
                opb = {17'd0, rustle_gain_reg};
            end
            OP_HITENV:
            begin
                opa = MUL_W'(tp2_reg);
                opb = {17'd0, hit_env_reg};
            end
            OP_HITGAIN:
            begin
                opa = MUL_W'(t_reg);
                opb = {17'd0, hit_gain_reg};
            end
            OP_ATTACK:
            begin
                opa = MUL_W'(acc_reg);
                opb = {17'd0, ENV_ONE - attack_env_reg};
            end
            OP_DECAY:
            begin
                opa = MUL_W'(acc_reg);
                opb = {17'd0, decay_env_reg};
            end
            OP_ENV_A:
            begin
                opa = {17'd0, attack_env_reg};
                opb = {18'd0, attack_factor_reg};
            end
            OP_ENV_D:
            begin
                opa = {17'd0, decay_env_reg};
                opb = {18'd0, decay_factor_reg};
            end
            default:
            begin
                opa = {17'd0, hit_env_reg};
                opb = {18'd0, hit_factor_reg};
            end
        endcase
    end

    fnv_mul u_mul (
        .clk  (clk),
        .en   (state_reg == ST_RUN && !phase_reg),
        .opa  (opa),
        .opb  (opb),
        .prod (prod)
    );

    // Output scaling and saturation: mix = floor(prod / 2^15), then Q2.22 to sample
    always_comb
    begin
        smp_shift = ((prod >>> 15) <<< (SAMPLE_BITS - 1)) >>> 22;
        if (smp_shift > SMP_MAX)
            smp_sat = SMP_MAX[SAMPLE_BITS-1:0];
        else if (smp_shift < SMP_MIN)
            smp_sat = SMP_MIN[SAMPLE_BITS-1:0];
        else
            smp_sat = smp_shift[SAMPLE_BITS-1:0];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= FIRST_STEP;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (m_axis_tready && !smp_wb)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_RUN;
                        phase_reg <= 1'b0;
                        step_reg  <= s_axis_tuser ? FIRST_STEP : FIRST_RUN_STEP;
                    end
                end
                ST_RUN:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else if (!wb_hold)
                    begin
                        phase_reg <= 1'b0;
                        if (op == OP_DECAY)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= smp_sat;
                        end
                        if (step_reg == LAST_STEP)
                            state_reg <= ST_IDLE;
                        else
                            step_reg <= step_reg + 5'd1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Voice state: seed load on accept, restart on a start accept, write back on the second phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= '0;
            rng_reg        <= '0;
            noise_reg      <= '0;
            bp1_reg        <= '0;
            bp2_reg        <= '0;
            tp_reg         <= '0;
            tp1_reg        <= '0;
            tp2_reg        <= '0;
            hp_reg         <= '0;
            t_reg          <= '0;
            acc_reg        <= '0;
            attack_env_reg <= ENV_ONE;
            decay_env_reg  <= ENV_ONE;
            hit_env_reg    <= ENV_ONE;
        end
        else
        begin
            // High pass output follows the two poles continuously
            hp_reg <= fnv_sat24(26'(bp2_reg) - 26'(tp_reg));
            if (in_fire)
            begin
                seed_reg <= s_axis_tdata;
                if (s_axis_tuser)
                begin
                    bp1_reg        <= '0;
                    bp2_reg        <= '0;
                    tp_reg         <= '0;
                    tp1_reg        <= '0;
                    tp2_reg        <= '0;
                    attack_env_reg <= ENV_ONE;
                    decay_env_reg  <= ENV_ONE;
                    hit_env_reg    <= ENV_ONE;
                end
            end
            else if (state_reg == ST_RUN && phase_reg && !wb_hold)
            begin
                unique case (op)
                    OP_SEED, OP_LCG: rng_reg <= prod[31:0] + ADD_C;
                    OP_HASH:    noise_reg <= fnv_noise(prod[31:0]);
                    OP_LP_B1:   bp1_reg <= fnv_lp_update(bp1_reg, prod);
                    OP_LP_B2:   bp2_reg <= fnv_lp_update(bp2_reg, prod);
                    OP_LP_THIN: tp_reg  <= fnv_lp_update(tp_reg, prod);
                    OP_LP_T1:   tp1_reg <= fnv_lp_update(tp1_reg, prod);
                    OP_LP_T2:   tp2_reg <= fnv_lp_update(tp2_reg, prod);
                    OP_RUSTLE:  acc_reg <= $signed(prod[41:14]);
                    OP_HITENV:  t_reg   <= $signed(prod[39:15]);
                    OP_HITGAIN: acc_reg <= acc_reg + $signed(prod[41:14]);
                    OP_ATTACK:  acc_reg <= $signed(prod[42:15]);
                    OP_DECAY:   acc_reg <= acc_reg;
                    OP_ENV_A:   attack_env_reg <= prod[30:15];
                    OP_ENV_D:   decay_env_reg  <= prod[30:15];
                    default:    hit_env_reg    <= prod[30:15];
                endcase
            end
        end
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after accept");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= LAST_STEP)
        else $error("micro-program step out of range");

    a_env_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        attack_env_reg <= ENV_ONE && decay_env_reg <= ENV_ONE && hit_env_reg <= ENV_ONE)
        else $error("envelope above one");

    a_sample_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && phase_reg && op == OP_DECAY && !wb_hold |=> m_axis_tvalid)
        else $error("sample write back lost");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the footstep noise voice: fixed-point voice predictor and stream checks.
`timescale 1ns / 100ps

module testbench;
    import fnv_pkg::*;

    localparam int NUM_REGS = 8;
    localparam int QUIET_CYCLES = 64;     // longer than a start tick
    localparam int STALL_LIMIT = 4000;    // cycles with no beat before giving up
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS = 190;

    localparam logic [31:0] EDGE_SEEDS [5] = '{
        32'h00000000, 32'hffffffff, SEED_XOR, 32'h80000000, 32'h00000001
    };

    typedef logic [NUM_REGS-1:0][15:0] reg_bank_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_SLOW
    } sink_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;   // seed[31:0]
    logic                       s_axis_tuser;   // start_req
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [SAMPLE_BITS-1:0]     m_axis_tdata;   // sample
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [2:0]                 cfg_index;
    logic [15:0]                cfg_data;

    footstep_noise_voice DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predicted voice state
    reg_bank_t   voice_regs;
    logic [31:0] lcg_state;
    longint      body_y1, body_y2, thin_y, thump_y1, thump_y2;
    longint      env_attack, env_decay, env_hit;

    // Expected samples, oldest first
    logic [SAMPLE_BITS-1:0] pending_samples [$];

    int errors;
    int ticks_sent;
    int starts_sent;
    int settings_loaded;
    int samples_checked;
    int full_scale_samples;

    // Sender burst shaping and receiver hold-off request
    int gap_max;
    int burst_left;
    int hold_req;

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat24(input longint v);
        return clip(v, -64'sd8388608, 64'sd8388607);
    endfunction

    function automatic logic [15:0] field_mask(input logic [2:0] idx);
        logic [15:0] m;
        case (idx)
            REG_RUSTLE_GAIN, REG_HIT_GAIN: m = 16'hffff;
            default:                       m = 16'h7fff;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] next_draw();
        logic [31:0] r;
        logic [31:0] w;
        lcg_state = lcg_state * MUL_A + ADD_C;
        r = lcg_state;
        w = ((r >> (r[31:28] + 32'd4)) ^ r) * MIX_M;
        return (w >> 22) ^ w;
    endfunction

    // White noise in Q2.22, range [-1, 1)
    function automatic longint noise_q22();
        logic [31:0] d;
        d = next_draw();
        return longint'(d[31:9]) - 64'sd4194304;
    endfunction

    // One pole step: y + floor(coef * (x - y) / 2^15), saturated
    function automatic longint smooth(input longint y, input longint coef, input longint x);
        return sat24(y + ((coef * (x - y)) >>> 15));
    endfunction

    function automatic void model_reset();
        voice_regs[REG_BODY_COEF]     = 16'd4096;
        voice_regs[REG_THIN_COEF]     = 16'd768;
        voice_regs[REG_THUMP_COEF]    = 16'd470;
        voice_regs[REG_ATTACK_FACTOR] = 16'd32155;
        voice_regs[REG_DECAY_FACTOR]  = 16'd32744;
        voice_regs[REG_HIT_FACTOR]    = 16'd32706;
        voice_regs[REG_RUSTLE_GAIN]   = 16'd9011;
        voice_regs[REG_HIT_GAIN]      = 16'd36045;
        lcg_state = 32'd0;
        body_y1 = 0;
        body_y2 = 0;
        thin_y = 0;
        thump_y1 = 0;
        thump_y2 = 0;
        env_attack = ENV_ONE;
        env_decay = ENV_ONE;
        env_hit = ENV_ONE;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] predict_sample(input logic start,
                                                              input logic [31:0] seed);
        longint x;
        longint hp;
        longint rustle;
        longint hit;
        longint mix;
        longint s;
        longint top;
        // restart: reseed, drop the jitter draw, clear filters, envelopes to one
        if (start) begin
            lcg_state = (seed ^ SEED_XOR) * MUL_A + ADD_C;
            void'(next_draw());
            body_y1 = 0;
            body_y2 = 0;
            thin_y = 0;
            thump_y1 = 0;
            thump_y2 = 0;
            env_attack = ENV_ONE;
            env_decay = ENV_ONE;
            env_hit = ENV_ONE;
        end
        // rustle: two-pole low pass, then high pass
        x = noise_q22();
        body_y1 = smooth(body_y1, longint'(voice_regs[REG_BODY_COEF]), x);
        body_y2 = smooth(body_y2, longint'(voice_regs[REG_BODY_COEF]), body_y1);
        thin_y = smooth(thin_y, longint'(voice_regs[REG_THIN_COEF]), body_y2);
        hp = sat24(body_y2 - thin_y);
        // thump: two-pole low pass
        x = noise_q22();
        thump_y1 = smooth(thump_y1, longint'(voice_regs[REG_THUMP_COEF]), x);
        thump_y2 = smooth(thump_y2, longint'(voice_regs[REG_THUMP_COEF]), thump_y1);
        // gains, envelopes, mix
        rustle = (hp * longint'(voice_regs[REG_RUSTLE_GAIN])) >>> 14;
        hit = (thump_y2 * env_hit) >>> 15;
        hit = (hit * longint'(voice_regs[REG_HIT_GAIN])) >>> 14;
        mix = ((rustle + hit) * (longint'(ENV_ONE) - env_attack)) >>> 15;
        mix = (mix * env_decay) >>> 15;
        top = longint'(1) << (SAMPLE_BITS - 1);
        s = clip((mix * top) >>> 22, -top, top - 1);
        if (s == top - 1 || s == -top)
            full_scale_samples++;
        // envelopes advance after the sample
        env_attack = (env_attack * longint'(voice_regs[REG_ATTACK_FACTOR])) >>> 15;
        env_decay = (env_decay * longint'(voice_regs[REG_DECAY_FACTOR])) >>> 15;
        env_hit = (env_hit * longint'(voice_regs[REG_HIT_FACTOR])) >>> 15;
        return s[SAMPLE_BITS-1:0];
    endfunction

    //------------------------------------------------------------------
    // Register value pickers
    //------------------------------------------------------------------
    function automatic logic [15:0] random_coef();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hffff;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Mostly close to one so the envelopes last
    function automatic logic [15:0] random_factor();
        logic [15:0] v;
        if ($urandom_range(0, 9) == 0)
            v = random_coef();
        else
            v = 16'(32767 - $urandom_range(0, 1200)) | 16'($urandom_range(0, 1) << 15);
        return v;
    endfunction

    function automatic logic [15:0] random_gain();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hffff;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic reg_bank_t make_bank(input logic [15:0] body, input logic [15:0] thin,
                                            input logic [15:0] thump, input logic [15:0] att,
                                            input logic [15:0] dec, input logic [15:0] hit,
                                            input logic [15:0] rgain, input logic [15:0] hgain);
        reg_bank_t b;
        b[REG_BODY_COEF]     = body;
        b[REG_THIN_COEF]     = thin;
        b[REG_THUMP_COEF]    = thump;
        b[REG_ATTACK_FACTOR] = att;
        b[REG_DECAY_FACTOR]  = dec;
        b[REG_HIT_FACTOR]    = hit;
        b[REG_RUSTLE_GAIN]   = rgain;
        b[REG_HIT_GAIN]      = hgain;
        return b;
    endfunction

    //------------------------------------------------------------------
    // Shared drivers
    //------------------------------------------------------------------
    // Send one tick beat, then maybe close the burst with a gap
    task automatic send_tick(input logic start, input logic [31:0] seed);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= start;
        s_axis_tdata <= seed;
        do @(posedge clk); while (!s_axis_tready);
        pending_samples.push_back(predict_sample(start, seed));
        ticks_sent++;
        if (start)
            starts_sent++;
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 30);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait for every expected sample
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // Write the whole register bank once the voice is idle
    task automatic load_regs(input reg_bank_t bank);
        logic [2:0] idx;
        wait_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        idx = REG_BODY_COEF;
        repeat (NUM_REGS) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= bank[idx];
            do @(posedge clk); while (!cfg_ready);
            voice_regs[idx] = bank[idx] & field_mask(idx);
            idx = idx + 3'd1;
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Well-formed footsteps: a start, then a run of plain ticks, rare stray starts
    task automatic run_voice(input int n_ticks);
        int sent;
        int run;
        sent = 0;
        while (sent < n_ticks) begin
            send_tick(1'b1, $urandom());
            sent++;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(3, 40);
            if (run > n_ticks - sent)
                run = n_ticks - sent;
            repeat (run) begin
                send_tick($urandom_range(0, 49) == 0, $urandom());
                sent++;
            end
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Ticks before any start run from the reset state; seed is ignored
    task automatic test_power_up_voice();
        gap_max = 5;
        send_tick(1'b0, 32'h00000000);
        send_tick(1'b0, 32'hffffffff);
        send_tick(1'b0, 32'h5a5a5a5a);
    endtask

    // Restarts on boundary seeds, including one that cancels the seed mask
    task automatic test_restart_seeds();
        foreach (EDGE_SEEDS[i]) begin
            send_tick(1'b1, EDGE_SEEDS[i]);
            send_tick(1'b0, ~EDGE_SEEDS[i]);
            send_tick(1'b0, EDGE_SEEDS[i]);
        end
        // back-to-back restarts with the same seed
        send_tick(1'b1, 32'hdeadbeef);
        send_tick(1'b1, 32'hdeadbeef);
        send_tick(1'b0, 32'h0);
    endtask

    // All-zero, all-ones (masked), saturating and default settings
    task automatic test_extreme_settings();
        gap_max = 0;
        load_regs(make_bank(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
        run_voice(40);
        gap_max = 3;
        load_regs(make_bank(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            16'hffff, 16'hffff));
        run_voice(40);
        // full gain, no high pass loss, instant attack: drives filters and output to the rails
        gap_max = 0;
        load_regs(make_bank(16'd32767, 16'd0, 16'd32767, 16'd0, 16'd32767, 16'd32767,
                            16'd65535, 16'd65535));
        run_voice(60);
        gap_max = 12;
        load_regs(make_bank(16'd4096, 16'd768, 16'd470, 16'd32155, 16'd32744, 16'd32706,
                            16'd9011, 16'd36045));
        run_voice(60);
    endtask

    // Receiver holds off while ticks keep coming, then sender waits for all samples
    task automatic test_backpressure();
        gap_max = 0;
        hold_req = HOLD_CYCLES;
        send_tick(1'b1, $urandom());
        repeat (11) send_tick(1'b0, $urandom());
        wait_drain();
        repeat (10) send_tick(1'b0, $urandom());
    endtask

    // Random settings per phase with varied sender idling
    task automatic test_random_voice();
        repeat (RANDOM_PHASES) begin
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 3;
                2:       gap_max = 12;
                default: gap_max = 40;
            endcase
            load_regs(make_bank(random_coef(), random_coef(), random_coef(),
                                random_factor(), random_factor(), random_factor(),
                                random_gain(), random_gain()));
            run_voice(PHASE_TICKS);
        end
    endtask

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: own stall pattern plus the requested hold-off
    initial begin
        sink_mode_t mode;
        int mode_left;
        int hold_left;
        int period;
        int duty;
        int count;
        mode = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        period = 2;
        duty = 1;
        count = 0;
        forever begin
            @(posedge clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 400);
                    period = $urandom_range(2, 9);
                    duty = $urandom_range(1, period - 1);
                end
                mode_left--;
                count++;
                case (mode)
                    SINK_OPEN:    m_axis_tready <= 1'b1;
                    SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                    SINK_PATTERN: m_axis_tready <= ((count % period) < duty);
                    default:      m_axis_tready <= ((count % 64) >= 48);
                endcase
            end
        end
    end

    // Sample checker: every output beat against the oldest expectation
    initial begin
        logic [SAMPLE_BITS-1:0] want;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected sample beat: expected none, actual %0d",
                             $time, $signed(m_axis_tdata));
                end
                else begin
                    want = pending_samples.pop_front();
                    samples_checked++;
                    if (m_axis_tdata !== want) begin
                        errors++;
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_axis_tdata));
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any accepted beat
    initial begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: timeout, no beat for %0d cycles, %0d samples outstanding",
                 $time, STALL_LIMIT, pending_samples.size());
        $display("Verification failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        errors = 0;
        ticks_sent = 0;
        starts_sent = 0;
        settings_loaded = 0;
        samples_checked = 0;
        full_scale_samples = 0;
        gap_max = 0;
        burst_left = 0;
        hold_req = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 32'h0;
        s_axis_tuser <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BODY_COEF;
        cfg_data <= 16'h0;
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_voice();
        test_restart_seeds();
        test_extreme_settings();
        test_backpressure();
        test_random_voice();

        wait_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("Run covered %0d ticks (%0d restarts) over %0d register settings",
                 ticks_sent, starts_sent, settings_loaded);
        $display("%0d samples checked, %0d of them at full scale, %0d errors",
                 samples_checked, full_scale_samples, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== footstep_noise_voice.f =====
hw/rtl/fnv_pkg.sv
hw/rtl/fnv_mul.sv
hw/rtl/footstep_noise_voice.sv
tb/sv/testbench.sv
